>>> hw/rtl/lruk_pkg.sv
package lruk_pkg;

    localparam int FRAME_TOTAL = 64;
    localparam int MAX_HISTORY = 8;
    localparam int FID_W       = $clog2(FRAME_TOTAL);
    localparam int SLOT_W      = $clog2(MAX_HISTORY);
    localparam int LEN_W       = $clog2(MAX_HISTORY + 1);
    localparam int CNT_W       = $clog2(FRAME_TOTAL + 1);
    localparam int ADDR_W      = FID_W + SLOT_W;
    localparam int STAMP_W     = 32;
    localparam int K_W         = 4;
    localparam int FU_W        = 7;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef enum logic [1:0] {
        FN_ACCESS = 2'd0,
        FN_MARK   = 2'd1,
        FN_REMOVE = 2'd2,
        FN_EVICT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ID    = 2'd1,
        ST_NOT_EVICT = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_K_VALUE       = 2'd0,
        CFG_FRAMES_IN_USE = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch_req;
        logic exec_op;
        logic scan_clear;
        logic scan_step;
        logic finish_evict;
    } dp_cmd_t;

    typedef struct packed {
        logic is_evict;
        logic out_free;
        logic scan_end;
    } dp_status_t;

endpackage

>>> hw/rtl/lruk_ctrl.sv
module lruk_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lruk_pkg::dp_status_t sts,
    output lruk_pkg::dp_cmd_t    cmd
);
    import lruk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (sts.is_evict)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.latch_req = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.scan_clear = sts.is_evict;
                cmd.exec_op    = !sts.is_evict && sts.out_free;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish_evict = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/lruk_datapath.sv
module lruk_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_index,
    input  logic [lruk_pkg::FU_W-1:0]           cfg_data,
    input  logic [lruk_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [1:0]                          s_tuser,
    input  lruk_pkg::dp_cmd_t                   cmd,
    output lruk_pkg::dp_status_t                sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [lruk_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lruk_pkg::*;

    // configuration
    logic [K_W-1:0]  k_value_reg;
    logic [FU_W-1:0] frames_in_use_reg;
    logic [LEN_W-1:0] k_eff;
    logic [CNT_W-1:0] frames_eff;

    // request
    func_t            req_func_reg;
    logic [FID_W-1:0] req_fid_reg;
    logic             req_flag_reg;

    // per-frame state
    logic                  tracked_reg [FRAME_TOTAL];
    logic                  evict_reg   [FRAME_TOTAL];
    logic [LEN_W-1:0]      len_reg     [FRAME_TOTAL];
    logic [SLOT_W-1:0]     head_reg    [FRAME_TOTAL];
    logic [STAMP_W-1:0]    ts_reg;
    logic [STAMP_W-1:0]    ts_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // stamp memory
    logic [STAMP_W-1:0] mem [FRAME_TOTAL * MAX_HISTORY];
    logic [STAMP_W-1:0] mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;

    // scan
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               pipe_vld_reg;
    logic [FID_W-1:0]   pipe_id_reg;
    logic               pipe_short_reg;
    logic               found_reg;
    logic               found_short_reg;
    logic [FID_W-1:0]   best_id_reg;
    logic [STAMP_W-1:0] best_stamp_reg;

    // output
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // combinational
    logic [FID_W-1:0]  meta_idx;
    logic              cur_tracked;
    logic              cur_evict;
    logic [LEN_W-1:0]  cur_len;
    logic [SLOT_W-1:0] cur_head;
    logic              bad_id;
    status_t           op_status;
    logic [LEN_W-1:0]  acc_len;
    logic [SLOT_W-1:0] acc_head;
    logic [LEN_W-1:0]  drop;
    logic              scan_issue;
    logic              scan_elig;
    logic              scan_short;
    logic [LEN_W-1:0]  scan_off;
    logic              take;
    logic              do_clear;
    logic [FID_W-1:0]  clear_idx;

    always_comb
    begin
        priority if (k_value_reg == '0)
        begin
            k_eff = LEN_W'(1);
        end
        else if (k_value_reg > K_W'(MAX_HISTORY))
        begin
            k_eff = LEN_W'(MAX_HISTORY);
        end
        else
        begin
            k_eff = LEN_W'(k_value_reg);
        end
        priority if (frames_in_use_reg == '0)
        begin
            frames_eff = CNT_W'(1);
        end
        else if (CNT_W'(frames_in_use_reg) > CNT_W'(FRAME_TOTAL))
        begin
            frames_eff = CNT_W'(FRAME_TOTAL);
        end
        else
        begin
            frames_eff = CNT_W'(frames_in_use_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_value_reg       <= K_W'(2);
            frames_in_use_reg <= FU_W'(64);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == 1'(CFG_K_VALUE))
            begin
                k_value_reg <= cfg_data[K_W-1:0];
            end
            else
            begin
                frames_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_func_reg <= func_t'(s_tuser);
            req_fid_reg  <= s_tdata[FID_W-1:0];
            req_flag_reg <= s_tdata[FID_W];
        end
    end

    // one read site for frame state: request frame, or the scan position
    assign meta_idx    = cmd.scan_step ? scan_cnt_reg[FID_W-1:0] : req_fid_reg;
    assign cur_tracked = tracked_reg[meta_idx];
    assign cur_evict   = evict_reg[meta_idx];
    assign cur_len     = len_reg[meta_idx];
    assign cur_head    = head_reg[meta_idx];

    assign bad_id = (CNT_W'(req_fid_reg) >= frames_eff);

    always_comb
    begin
        op_status  = ST_OK;
        ts_next    = ts_reg;
        count_next = count_reg;
        acc_len    = cur_tracked ? cur_len : '0;
        acc_head   = cur_tracked ? cur_head : '0;
        drop       = '0;
        mem_we     = 1'b0;
        do_clear   = 1'b0;
        clear_idx  = req_fid_reg;
        if (cmd.exec_op)
        begin
            priority if (bad_id)
            begin
                op_status = ST_BAD_ID;
            end
            else if (req_func_reg == FN_ACCESS)
            begin
                if (ts_reg == STAMP_MAX)
                begin
                    op_status = ST_OVERFLOW;
                end
                else
                begin
                    ts_next = ts_reg + STAMP_W'(1);
                end
                // keep the newest k-1 stamps by advancing the ring head
                if (acc_len >= k_eff)
                begin
                    drop     = acc_len - (k_eff - LEN_W'(1));
                    acc_head = acc_head + drop[SLOT_W-1:0];
                    acc_len  = k_eff - LEN_W'(1);
                end
                mem_we = 1'b1;
            end
            else if (req_func_reg == FN_MARK)
            begin
                if (cur_tracked && cur_evict && !req_flag_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                if (cur_tracked && !cur_evict && req_flag_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (cur_tracked)
                begin
                    if (!cur_evict)
                    begin
                        op_status = ST_NOT_EVICT;
                    end
                    else
                    begin
                        do_clear   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
        end
        if (cmd.finish_evict && found_reg)
        begin
            do_clear   = 1'b1;
            clear_idx  = best_id_reg;
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign mem_waddr = {req_fid_reg, acc_head + acc_len[SLOT_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_TOTAL; i++)
            begin
                tracked_reg[i] <= 1'b0;
                evict_reg[i]   <= 1'b0;
                len_reg[i]     <= '0;
                head_reg[i]    <= '0;
            end
            ts_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            ts_reg <= ts_next;
            if (cmd.exec_op || cmd.finish_evict)
            begin
                count_reg <= count_next;
            end
            if (mem_we)
            begin
                if (!cur_tracked)
                begin
                    evict_reg[req_fid_reg] <= 1'b0;
                end
                tracked_reg[req_fid_reg] <= 1'b1;
                len_reg[req_fid_reg]     <= acc_len + LEN_W'(1);
                head_reg[req_fid_reg]    <= acc_head;
            end
            if (cmd.exec_op && !bad_id && req_func_reg == FN_MARK && cur_tracked)
            begin
                evict_reg[req_fid_reg] <= req_flag_reg;
            end
            if (do_clear)
            begin
                tracked_reg[clear_idx] <= 1'b0;
                evict_reg[clear_idx]   <= 1'b0;
                len_reg[clear_idx]     <= '0;
            end
        end
    end

    // scan: issue a stamp read for one frame, compare it in the following cycle
    assign scan_issue = (scan_cnt_reg < CNT_W'(FRAME_TOTAL));
    assign scan_elig  = scan_issue && cur_tracked && cur_evict && (cur_len != '0);
    assign scan_short = (cur_len < k_eff);
    assign scan_off   = scan_short ? '0 : (cur_len - k_eff);
    assign mem_raddr  = {meta_idx, cur_head + scan_off[SLOT_W-1:0]};

    assign take = pipe_vld_reg &&
                  (!found_reg ||
                   (pipe_short_reg && !found_short_reg) ||
                   ((pipe_short_reg == found_short_reg) && (mem_rdata_reg < best_stamp_reg)));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= ts_next;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            pipe_vld_reg <= scan_elig;
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            pipe_id_reg    <= scan_cnt_reg[FID_W-1:0];
            pipe_short_reg <= scan_short;
            if (take)
            begin
                found_short_reg <= pipe_short_reg;
                best_id_reg     <= pipe_id_reg;
                best_stamp_reg  <= mem_rdata_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.exec_op || cmd.finish_evict)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_op)
        begin
            m_tdata_reg <= {count_next, op_status, {FID_W{1'b0}}, 1'b0};
        end
        else if (cmd.finish_evict)
        begin
            m_tdata_reg <= {count_next, ST_OK,
                            found_reg ? best_id_reg : {FID_W{1'b0}}, found_reg};
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.is_evict = (req_func_reg == FN_EVICT);
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.scan_end = (scan_cnt_reg == CNT_W'(FRAME_TOTAL));

endmodule

>>> hw/rtl/lru_k_frame_replacer_core.sv
// Channel   Direction  Signals                       Content
// s_axis    in         s_tvalid/s_tready             request: func, frame index, evictable_flag
// m_axis    out        m_tvalid/m_tready             result: victim, status, evictable count
// cfg       in         cfg_valid/cfg_ready           register index and write data
//
// Access, mark and remove latch the request in S_IDLE and load the result register
// in S_EXEC, which waits while an earlier result is held; s_tready is high only
// in S_IDLE, so the next request waits for that load. Evict walks all 64 frames
// through the stamp memory's one read port, one frame a cycle, compares each read
// stamp once it is registered, and loads the result register in S_FINISH.
// rst_n clears frame state and counters and resets config; the stamp memory is not cleared.
// A result waiting on m_tready holds the block before the result load only.
module lru_k_frame_replacer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] frame index, [6] evictable_flag, [7] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] victim_valid, [6:1] victim_frame,
                                   // [8:7] status, [15:9] evictable_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index, // 0 k_value, 1 frames_in_use
    input  logic [6:0]  cfg_data
);
    import lruk_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    // the user writes config only when idle; the block does not enforce it: take every transfer at once
    assign cfg_ready = 1'b1;

    lruk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lruk_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hw/rtl/lruk_checker.sv
module lruk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import lruk_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == '0)
        else $error("victim frame without victim");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[8:7] == ST_OK)
        else $error("victim with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:9] <= 7'(FRAME_TOTAL))
        else $error("evictable count out of range");

endmodule

bind lru_k_frame_replacer_core lruk_checker u_lruk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
